FILE: design/neighbor_color_median_core_assert.svh
// assertion macros for the neighbour colour median core
// expects a clock named clk and an active-low reset named rst_n in scope
`ifndef NEIGHBOR_COLOR_MEDIAN_CORE_ASSERT_SVH
`define NEIGHBOR_COLOR_MEDIAN_CORE_ASSERT_SVH

// condition holds in the same cycle
`define NCM_ASSERT_NOW(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// trigger implies consequence in the next cycle
`define NCM_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/ncm_pkg.sv
// shared constants and types of the neighbour colour median core
// no dependencies
package ncm_pkg;

    // colour channels carried per item
    localparam int NUM_CHAN = 3;
    // width of one channel field on the stream ports
    localparam int FIELD_W = 8;
    localparam int TDATA_W = NUM_CHAN * FIELD_W;

    // configuration register file
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;
    localparam int COUNT_W = 5;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd16;
    localparam logic REG_NEIGHBOR_COUNT = 1'b0;

    // control handed to every cell of the insertion chain
    typedef struct packed {
        logic load;     // an item is accepted this cycle
        logic active;   // cell holds an entry of the current point
    } cell_ctrl_t;

endpackage

FILE: design/neighbor_color_median_core.sv
// top level of the neighbour colour median core
// depends on ncm_pkg, ncm_cell, ncm_regs and the assertion header
`include "neighbor_color_median_core_assert.svh"

// Takes the red, green and blue values of a point's neighbours, one neighbour
// per item, and inserts each channel into its own ascending order held in a
// chain of MAX_NEIGHBORS cells. Once neighbor_count items (0 taken as 1, above
// MAX_NEIGHBORS taken as MAX_NEIGHBORS) have arrived, one result item carries
// the element at ascending index count/2 of each channel (the upper median for
// an even count) and the next point starts. An item is accepted every cycle:
// while s_tready is high, as every cell compares and shifts in parallel. The
// item completing a point sets a pending flag, and the output register then
// picks the median cell once the output stage is free; a result that is not
// taken blocks input only once a second result is due.
module neighbor_color_median_core #(
    parameter int MAX_NEIGHBORS = 16,
    parameter int CHANNEL_BITS = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ncm_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [ncm_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [ncm_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready,
    // neighbour items
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ncm_pkg::TDATA_W-1:0]     s_tdata,  // red [7:0], green [15:8], blue [23:16]
    // median items
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ncm_pkg::TDATA_W-1:0]     m_tdata   // median_red [7:0], median_green [15:8],
                                                      // median_blue [23:16]
);

    localparam int NCH   = ncm_pkg::NUM_CHAN;
    localparam int FW    = ncm_pkg::FIELD_W;
    localparam int CNT_W = $clog2(MAX_NEIGHBORS + 1);
    localparam int IDX_W = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;

    logic [CNT_W-1:0]                 eff_count;
    logic [CNT_W-1:0]                 gathered_reg;
    logic [CNT_W-1:0]                 gathered_next;
    logic [CNT_W-1:0]                 gathered_inc;
    logic [IDX_W-1:0]                 mid_reg;
    logic [IDX_W-1:0]                 mid_next;
    logic                             pend_reg;
    logic                             pend_next;
    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic [NCH-1:0][FW-1:0]           out_data_reg;
    logic [NCH-1:0][FW-1:0]           out_data_next;
    logic                             accept;
    logic                             emit;
    logic                             out_free;
    logic                             out_load;
    logic [NCH-1:0][CHANNEL_BITS-1:0] new_data;
    logic [NCH-1:0][CHANNEL_BITS-1:0] cell_data [MAX_NEIGHBORS];
    logic [NCH-1:0]                   cell_le [MAX_NEIGHBORS];

    // configuration register
    ncm_regs #(
        .MAX_NEIGHBORS (MAX_NEIGHBORS),
        .CNT_W         (CNT_W)
    ) u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .eff_count (eff_count)
    );

    // handshake: the chain must hold while a result waits for the output stage
    assign out_free = !out_valid_reg || m_tready;
    assign out_load = pend_reg && out_free;
    assign s_tready = !pend_reg || out_free;
    assign accept   = s_tvalid && s_tready;

    // channel values at storage width
    always_comb
    begin
        for (int c = 0; c < NCH; c++)
            new_data[c] = CHANNEL_BITS'(s_tdata[c*FW +: FW]);
    end

    // insertion chain
    for (genvar k = 0; k < MAX_NEIGHBORS; k++)
    begin : g_cell
        ncm_pkg::cell_ctrl_t                ctrl;
        logic [NCH-1:0][CHANNEL_BITS-1:0]   prev_data;
        logic [NCH-1:0]                     prev_le;

        assign ctrl = '{load: accept, active: (CNT_W'(k) < gathered_reg)};

        if (k == 0)
        begin : g_head
            assign prev_data = new_data;
            assign prev_le   = '1;
        end
        else
        begin : g_body
            assign prev_data = cell_data[k-1];
            assign prev_le   = cell_le[k-1];
        end

        ncm_cell #(
            .CHAN_BITS (CHANNEL_BITS)
        ) u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .new_data  (new_data),
            .prev_data (prev_data),
            .prev_le   (prev_le),
            .data      (cell_data[k]),
            .le        (cell_le[k])
        );
    end

    // point progress and median position
    assign gathered_inc = gathered_reg + CNT_W'(1);
    assign emit         = (gathered_inc >= eff_count);

    always_comb
    begin
        gathered_next = gathered_reg;
        mid_next      = mid_reg;
        pend_next     = pend_reg;
        if (out_load)
            pend_next = 1'b0;
        if (accept)
        begin
            gathered_next = emit ? '0 : gathered_inc;
            if (emit)
            begin
                pend_next = 1'b1;
                mid_next  = IDX_W'(eff_count >> 1);
            end
        end
    end

    // output stage: picks the median cell once the insertion has settled
    always_comb
    begin
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            for (int c = 0; c < NCH; c++)
                out_data_next[c] = FW'(cell_data[mid_reg][c]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gathered_reg  <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            gathered_reg  <= gathered_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mid_reg      <= mid_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // checks
    `NCM_ASSERT_NOW(a_gathered_range, gathered_reg < CNT_W'(MAX_NEIGHBORS), "gathered overflow")
    `NCM_ASSERT_NEXT(a_emit_pending, accept && emit, pend_reg, "completed point lost")
    `NCM_ASSERT_NEXT(a_emit_restart, accept && emit, gathered_reg == '0, "point not restarted")
    `NCM_ASSERT_NEXT(a_result_shown, out_load, m_tvalid, "pending result not shown")

endmodule

FILE: design/ncm_cell.sv
// one cell of the insertion chain: holds one sorted entry per colour channel
// depends on ncm_pkg
module ncm_cell #(
    parameter int CHAN_BITS = 8
) (
    input  logic                                          clk,
    input  ncm_pkg::cell_ctrl_t                           ctrl,
    input  logic [ncm_pkg::NUM_CHAN-1:0][CHAN_BITS-1:0]   new_data,
    input  logic [ncm_pkg::NUM_CHAN-1:0][CHAN_BITS-1:0]   prev_data,
    input  logic [ncm_pkg::NUM_CHAN-1:0]                  prev_le,
    output logic [ncm_pkg::NUM_CHAN-1:0][CHAN_BITS-1:0]   data,
    output logic [ncm_pkg::NUM_CHAN-1:0]                  le
);

    logic [ncm_pkg::NUM_CHAN-1:0][CHAN_BITS-1:0] data_reg;
    logic [ncm_pkg::NUM_CHAN-1:0][CHAN_BITS-1:0] data_next;

    // per channel: keep if stored value is not above the new one,
    // take the new value at the insertion point, else shift from the left
    always_comb
    begin
        for (int c = 0; c < ncm_pkg::NUM_CHAN; c++)
        begin
            le[c] = ctrl.active && (data_reg[c] <= new_data[c]);
            if (le[c])
                data_next[c] = data_reg[c];
            else if (prev_le[c])
                data_next[c] = new_data[c];
            else
                data_next[c] = prev_data[c];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
            data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

FILE: design/ncm_regs.sv
// apb configuration register and effective neighbour count
// depends on ncm_pkg
module ncm_regs #(
    parameter int MAX_NEIGHBORS = 16,
    parameter int CNT_W = 5
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ncm_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [ncm_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [ncm_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready,
    output logic [CNT_W-1:0]                eff_count
);

    logic [ncm_pkg::COUNT_W-1:0] count_reg;
    logic [ncm_pkg::COUNT_W-1:0] count_next;
    logic                        wr_en;
    logic                        sel_count;

    assign pready    = 1'b1;
    assign sel_count = (paddr[2] == ncm_pkg::REG_NEIGHBOR_COUNT);
    assign wr_en     = psel && penable && pwrite && sel_count;

    // register write
    always_comb
    begin
        count_next = count_reg;
        if (wr_en)
            count_next = pwdata[ncm_pkg::COUNT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= ncm_pkg::COUNT_RESET;
        else
            count_reg <= count_next;
    end

    // read back
    always_comb
    begin
        prdata = '0;
        if (sel_count)
            prdata = ncm_pkg::CFG_DATA_W'(count_reg);
    end

    // zero acts as one, large values saturate to the chain length
    always_comb
    begin
        if (count_reg == '0)
            eff_count = CNT_W'(1);
        else if (32'(count_reg) > MAX_NEIGHBORS)
            eff_count = CNT_W'(MAX_NEIGHBORS);
        else
            eff_count = CNT_W'(count_reg);
    end

endmodule

FILE: dv/neighbor_color_median_core_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for neighbor_color_median_core: directed table, then random points
// depends on ncm_pkg and the core; medians are predicted by a sorted-insertion model held here

module neighbor_color_median_core_tb;

    localparam int MAX_NB = 16;
    localparam int REG_UNUSED = 1;          // unmapped register slot, writes ignored
    localparam int RANDOM_ITEMS = 1700;
    localparam int SETTLE_CYCLES = 4;
    localparam int QUIET_LIMIT = 5000;
    localparam int N_ROWS = 23;

    // one item on either stream, red in the lowest byte
    typedef struct packed {
        logic [ncm_pkg::FIELD_W-1:0] blue;
        logic [ncm_pkg::FIELD_W-1:0] green;
        logic [ncm_pkg::FIELD_W-1:0] red;
    } rgb_t;

    typedef enum {ROW_NEIGHBOR, ROW_WRITE} row_kind_t;

    typedef struct {
        row_kind_t                   kind;
        int unsigned                 reg_idx;
        logic [31:0]                 wdata;
        logic [ncm_pkg::FIELD_W-1:0] red;
        logic [ncm_pkg::FIELD_W-1:0] green;
        logic [ncm_pkg::FIELD_W-1:0] blue;
        bit                          typed;
        logic [ncm_pkg::FIELD_W-1:0] want_red;
        logic [ncm_pkg::FIELD_W-1:0] want_green;
        logic [ncm_pkg::FIELD_W-1:0] want_blue;
    } stim_row_t;

    logic                            clk;
    logic                            rst_n = 1'b0;
    logic                            psel = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite = 1'b0;
    logic [ncm_pkg::CFG_ADDR_W-1:0]  paddr = '0;
    logic [ncm_pkg::CFG_DATA_W-1:0]  pwdata = '0;
    logic [ncm_pkg::CFG_DATA_W-1:0]  prdata;
    logic                            pready;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [ncm_pkg::TDATA_W-1:0]     s_tdata = '0;   // red [7:0], green [15:8], blue [23:16]
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [ncm_pkg::TDATA_W-1:0]     m_tdata;        // median_red [7:0], median_green [15:8],
                                                     // median_blue [23:16]

    // predictor state
    logic [ncm_pkg::COUNT_W-1:0]     count_reg = ncm_pkg::COUNT_RESET;
    logic [ncm_pkg::FIELD_W-1:0]     order [ncm_pkg::NUM_CHAN][MAX_NB];
    int unsigned                     held = 0;
    rgb_t                            pending_medians [$];
    int unsigned                     err_count = 0;
    bit                              steady = 1'b0;
    int unsigned                     stall_left = 0;
    int unsigned                     quiet = 0;

    // directed items: mid-point lowering, count one, count zero, pairs, ties
    stim_row_t directed_rows [N_ROWS] = '{
        '{ROW_NEIGHBOR, 0, 0, 200, 10, 90, 0, 0, 0, 0},
        '{ROW_NEIGHBOR, 0, 0, 0, 255, 17, 0, 0, 0, 0},
        '{ROW_NEIGHBOR, 0, 0, 255, 0, 128, 0, 0, 0, 0},
        '{ROW_NEIGHBOR, 0, 0, 33, 44, 55, 0, 0, 0, 0},
        '{ROW_NEIGHBOR, 0, 0, 128, 128, 128, 0, 0, 0, 0},
        '{ROW_NEIGHBOR, 0, 0, 7, 250, 3, 0, 0, 0, 0},
        '{ROW_WRITE, ncm_pkg::REG_NEIGHBOR_COUNT, 32'd3, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_NEIGHBOR, 0, 0, 60, 70, 80, 0, 0, 0, 0},
        '{ROW_WRITE, ncm_pkg::REG_NEIGHBOR_COUNT, 32'hFFFF_FFE1, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_NEIGHBOR, 0, 0, 0, 0, 0, 1, 0, 0, 0},
        '{ROW_NEIGHBOR, 0, 0, 255, 255, 255, 1, 255, 255, 255},
        '{ROW_NEIGHBOR, 0, 0, 8'h55, 8'hAA, 8'h0F, 1, 8'h55, 8'hAA, 8'h0F},
        '{ROW_WRITE, ncm_pkg::REG_NEIGHBOR_COUNT, 32'd0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_NEIGHBOR, 0, 0, 8'hA5, 8'h5A, 8'hC3, 1, 8'hA5, 8'h5A, 8'hC3},
        '{ROW_NEIGHBOR, 0, 0, 8'hFF, 8'h00, 8'h80, 1, 8'hFF, 8'h00, 8'h80},
        '{ROW_WRITE, ncm_pkg::REG_NEIGHBOR_COUNT, 32'd2, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_NEIGHBOR, 0, 0, 10, 200, 0, 0, 0, 0, 0},
        '{ROW_NEIGHBOR, 0, 0, 20, 100, 255, 1, 20, 200, 255},
        '{ROW_WRITE, ncm_pkg::REG_NEIGHBOR_COUNT, 32'd3, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_WRITE, REG_UNUSED, 32'd1, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_NEIGHBOR, 0, 0, 5, 5, 5, 0, 0, 0, 0},
        '{ROW_NEIGHBOR, 0, 0, 5, 5, 5, 0, 0, 0, 0},
        '{ROW_NEIGHBOR, 0, 0, 1, 9, 5, 1, 5, 5, 5}
    };

    neighbor_color_median_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // count register as the core uses it: zero means one, saturates at the depth
    function automatic int unsigned live_count(input logic [ncm_pkg::COUNT_W-1:0] c);
        if (c == 0)
            return 1;
        if (c > MAX_NB)
            return MAX_NB;
        return c;
    endfunction

    // insert one neighbour per channel; returns 1 with the medians when the point closes
    function automatic bit fold_neighbor(input rgb_t px, output rgb_t med);
        logic [ncm_pkg::FIELD_W-1:0] v [ncm_pkg::NUM_CHAN];
        int unsigned need;
        int unsigned pos;
        int unsigned k;
        v[0] = px.red;
        v[1] = px.green;
        v[2] = px.blue;
        need = live_count(count_reg);
        med = '0;
        if (held >= MAX_NB)
            held = MAX_NB - 1;
        for (int c = 0; c < ncm_pkg::NUM_CHAN; c++)
        begin
            pos = 0;
            while (pos < held && order[c][pos] <= v[c])
                pos++;
            for (k = held; k > pos; k--)
                order[c][k] = order[c][k-1];
            order[c][pos] = v[c];
        end
        held++;
        if (held < need)
            return 1'b0;
        med.red = order[0][need/2];
        med.green = order[1][need/2];
        med.blue = order[2][need/2];
        held = 0;
        return 1'b1;
    endfunction

    // mostly short gaps, a few long ones, none in a steady phase
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // channel value with extremes and a narrow band to force ties
    function automatic logic [ncm_pkg::FIELD_W-1:0] draw_level();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2, 3: return ncm_pkg::FIELD_W'($urandom_range(100, 103));
            default: return ncm_pkg::FIELD_W'($urandom_range(0, 255));
        endcase
    endfunction

    // offer one neighbour item, hold until taken, then record its outcome
    task automatic send_neighbor(input rgb_t px, input bit typed, input rgb_t want);
        int unsigned gap;
        rgb_t med;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= ncm_pkg::TDATA_W'($urandom);
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= px;
        do @(posedge clk); while (!s_tready);
        if (fold_neighbor(px, med))
            pending_medians.push_back(typed ? want : med);
    endtask

    // stop sending and let every expected median come out
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_medians.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // register write, setup then access
    task automatic apb_write(input int unsigned idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ncm_pkg::CFG_ADDR_W'(idx * 4);
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if (idx == ncm_pkg::REG_NEIGHBOR_COUNT)
            count_reg = val[ncm_pkg::COUNT_W-1:0];
    endtask

    // read the count register back and compare with the model copy
    task automatic check_count_readback();
        logic [ncm_pkg::CFG_DATA_W-1:0] got;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= ncm_pkg::CFG_ADDR_W'(ncm_pkg::REG_NEIGHBOR_COUNT * 4);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        got = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if (got !== ncm_pkg::CFG_DATA_W'(count_reg))
        begin
            $error("neighbor_count readback: expected %0d, actual %0d", count_reg, got);
            err_count++;
        end
    endtask

    // receiver stalls
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
            if (!steady && $urandom_range(0, 3) == 0)
                stall_left = pick_gap();
        end
    end

    // median checker
    always @(posedge clk)
    begin
        rgb_t got;
        rgb_t exp_med;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (pending_medians.size() == 0)
            begin
                $error("median item with none expected: %h", m_tdata);
                err_count++;
            end
            else
            begin
                exp_med = pending_medians.pop_front();
                if (got.red !== exp_med.red)
                begin
                    $error("median_red: expected %0d, actual %0d", exp_med.red, got.red);
                    err_count++;
                end
                if (got.green !== exp_med.green)
                begin
                    $error("median_green: expected %0d, actual %0d", exp_med.green, got.green);
                    err_count++;
                end
                if (got.blue !== exp_med.blue)
                begin
                    $error("median_blue: expected %0d, actual %0d", exp_med.blue, got.blue);
                    err_count++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake on any port
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel || !rst_n)
            quiet = 0;
        else
            quiet++;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // stimulus
    initial
    begin : stimulus
        stim_row_t row;
        rgb_t px;
        rgb_t want;
        int unsigned sent_random;
        int unsigned phase;
        int unsigned need;
        int unsigned n_items;
        logic [ncm_pkg::COUNT_W-1:0] cfg;

        sent_random = 0;
        phase = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        check_count_readback();

        // directed table
        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.kind == ROW_WRITE)
            begin
                wait_idle();
                apb_write(row.reg_idx, row.wdata);
                if (row.reg_idx == ncm_pkg::REG_NEIGHBOR_COUNT)
                    check_count_readback();
            end
            else
            begin
                px.red = row.red;
                px.green = row.green;
                px.blue = row.blue;
                want.red = row.want_red;
                want.green = row.want_green;
                want.blue = row.want_blue;
                send_neighbor(px, row.typed, want);
            end
        end

        // random points, one setting per phase, some phases ending mid-point
        while (sent_random < RANDOM_ITEMS)
        begin
            wait_idle();
            if (phase == 0)
                cfg = 5'd31;
            else
                case ($urandom_range(0, 5))
                    0: cfg = 5'd1;
                    1: cfg = 5'd16;
                    2: cfg = 5'd0;
                    3: cfg = 5'd31;
                    4: cfg = ncm_pkg::COUNT_W'($urandom_range(2, 15));
                    default: cfg = ncm_pkg::COUNT_W'($urandom_range(0, 31));
                endcase
            if ($urandom_range(0, 7) == 0)
                apb_write(REG_UNUSED, $urandom);
            apb_write(ncm_pkg::REG_NEIGHBOR_COUNT, ($urandom & 32'hFFFF_FFE0) | 32'(cfg));
            check_count_readback();
            steady = ($urandom_range(0, 4) == 0);
            need = live_count(cfg);
            n_items = $urandom_range(1, 6) * need;
            if ($urandom_range(0, 3) == 0)
                n_items += $urandom_range(0, need - 1);
            repeat (n_items)
            begin
                px.red = draw_level();
                px.green = draw_level();
                px.blue = draw_level();
                send_neighbor(px, 1'b0, '0);
                sent_random++;
            end
            steady = 1'b0;
            phase++;
        end

        wait_idle();
        if (err_count == 0 && pending_medians.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+design
design/ncm_pkg.sv
design/ncm_cell.sv
design/ncm_regs.sv
design/neighbor_color_median_core.sv
dv/neighbor_color_median_core_tb.sv
